/* rtl/oct_pkg.sv */
// Package for the overlap crossfade time compressor: payload types, codes and constants.
package oct_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int POS_W       = 11;
    localparam int FIDX_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FLEN_W      = 11;
    localparam int HOP_W       = 10;
    localparam int DIV_CNT_W   = $clog2(SAMPLE_BITS);

    localparam logic [FLEN_W-1:0] FRAME_LEN_RST = 11'd1024;
    localparam logic [HOP_W-1:0]  HOP_LEN_RST   = 10'd512;
    localparam logic [FIDX_W-1:0] FRAMES_RST    = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LEN = 2'd0,
        CFG_HOP_LEN   = 2'd1,
        CFG_FRAMES    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] merged_sample;
        logic                          block_end;
        logic                          clip_end;
    } out_item_t;

    typedef struct packed {
        logic take_in;
        logic decide;
        logic mul_a;
        logic mul_b;
        logic prep_div;
        logic div_step;
        logic load_out;
    } oct_cmd_t;

    typedef struct packed {
        logic mix_go;
        logic out_free;
    } oct_status_t;

endpackage

/* rtl/oct_ctrl.sv */
// Controller state machine that sequences one request through the datapath.
module oct_ctrl import oct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  oct_status_t status,
    output oct_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_A,
        ST_MUL_B,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.mix_go ? ST_MUL_A : ST_IDLE;
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep_div = 1'b1;
                cnt_next     = DIV_CNT_W'(SAMPLE_BITS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FINISH: begin
                // The result waits here until the output register is free.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/oct_datapath.sv */
// Datapath: settings, frame counters, first-half store, crossfade multiply and serial divider.
module oct_datapath import oct_pkg::*; #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  oct_cmd_t              cmd,
    output oct_status_t           status,
    input  in_item_t              s_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    output out_item_t             m_data,
    input  logic                  m_ready
);

    localparam int STORE_DEPTH = MAX_FRAME / 2;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int NUM_W       = SAMPLE_BITS + POS_W + 2;

    // Settings.
    logic [FLEN_W-1:0] frame_len_reg;
    logic [HOP_W-1:0]  hop_len_reg;
    logic [FIDX_W-1:0] frames_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= FRAME_LEN_RST;
            hop_len_reg   <= HOP_LEN_RST;
            frames_reg    <= FRAMES_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_LEN: frame_len_reg <= cfg_data[FLEN_W-1:0];
                CFG_HOP_LEN:   hop_len_reg   <= cfg_data[HOP_W-1:0];
                CFG_FRAMES:    frames_reg    <= cfg_data[FIDX_W-1:0];
                default:       ;
            endcase
        end
    end

    // Captured request.
    in_item_t in_reg;
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            in_reg <= s_data;
        end
    end

    // Frame geometry after clamping.
    logic [31:0]       flen_w;
    logic [POS_W-1:0]  flen;
    logic [POS_W:0]    hmin_w;
    logic [POS_W-1:0]  hmin;
    logic [POS_W-1:0]  hop;
    logic [POS_W-1:0]  s_len;
    logic [POS_W:0]    two_s;

    always_comb begin
        flen_w = {{(32 - FLEN_W){1'b0}}, frame_len_reg};
        if (flen_w < 32'd2) begin
            flen_w = 32'd2;
        end
        if (flen_w > 32'(MAX_FRAME)) begin
            flen_w = 32'(MAX_FRAME);
        end
        flen   = flen_w[POS_W-1:0];
        hmin_w = {1'b0, flen} + 1'b1;
        hmin   = hmin_w[POS_W:1];
        hop    = {1'b0, hop_len_reg};
        if (hop < hmin) begin
            hop = hmin;
        end
        if (hop > flen - 1'b1) begin
            hop = flen - 1'b1;
        end
        s_len = flen - hop;
        two_s = {s_len, 1'b0};
    end

    // Frame counters and decision for the captured request.
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [FIDX_W-1:0] fidx_reg, fidx_next;
    logic [POS_W-1:0]  pos_eff;
    logic [FIDX_W-1:0] fidx_eff;
    logic [POS_W:0]    pos_inc;
    logic [FIDX_W:0]   fidx_inc;
    logic              active, store_hit, mix_hit;
    logic [POS_W-1:0]  idx;

    always_comb begin
        pos_eff   = in_reg.restart ? '0 : pos_reg;
        fidx_eff  = in_reg.restart ? '0 : fidx_reg;
        active    = fidx_eff < frames_reg;
        store_hit = pos_eff < s_len;
        mix_hit   = !store_hit && ({1'b0, pos_eff} < two_s) && (pos_eff < flen);
        idx       = pos_eff - s_len;
        pos_inc   = {1'b0, pos_eff} + 1'b1;
        fidx_inc  = {1'b0, fidx_eff} + 1'b1;
        pos_next  = pos_eff;
        fidx_next = fidx_eff;
        if (active) begin
            if (pos_inc >= {1'b0, flen}) begin
                pos_next  = '0;
                fidx_next = fidx_inc[FIDX_W-1:0];
            end else begin
                pos_next  = pos_inc[POS_W-1:0];
            end
        end
    end

    assign status.mix_go = active && mix_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fidx_reg <= '0;
        end else if (cmd.decide) begin
            pos_reg  <= pos_next;
            fidx_reg <= fidx_next;
        end
    end

    // First-half store.
    logic [POS_W+ADDR_W-1:0]       wr_wide, rd_wide;
    logic [ADDR_W-1:0]             wr_addr, rd_addr;
    logic signed [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg;

    assign wr_wide = {{ADDR_W{1'b0}}, pos_eff};
    assign rd_wide = {{ADDR_W{1'b0}}, idx};
    assign wr_addr = wr_wide[ADDR_W-1:0];
    assign rd_addr = rd_wide[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.decide && active && store_hit) begin
            store_mem[wr_addr] <= in_reg.sample;
        end
        if (cmd.decide) begin
            rd_reg <= store_mem[rd_addr];
        end
    end

    // Per-output bookkeeping.
    logic [POS_W-1:0] s_reg, i_reg;
    logic             bend_reg, cend_reg;
    logic             bend;

    assign bend = (idx == s_len - 1'b1);

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            s_reg    <= s_len;
            i_reg    <= idx;
            bend_reg <= bend;
            cend_reg <= bend && (fidx_inc == {1'b0, frames_reg});
        end
    end

    // Crossfade numerator, one product per cycle.
    logic [POS_W-1:0]        wa_u;
    logic signed [POS_W:0]   wa, wb;
    logic signed [NUM_W-1:0] prod_a, prod_b;
    logic signed [NUM_W-1:0] acc_reg;

    always_comb begin
        wa_u   = s_reg - i_reg;
        wa     = signed'({1'b0, wa_u});
        wb     = signed'({1'b0, i_reg});
        prod_a = NUM_W'(rd_reg) * NUM_W'(wa);
        prod_b = NUM_W'(in_reg.sample) * NUM_W'(wb);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_a) begin
            acc_reg <= prod_a;
        end else if (cmd.mul_b) begin
            acc_reg <= acc_reg + prod_b;
        end
    end

    // Restoring divider on the magnitude. The quotient fits in SAMPLE_BITS bits,
    // so the bits above that start as the partial remainder, already below S.
    logic [NUM_W-1:0]       mag;
    logic [POS_W-1:0]       rem_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic                   neg_reg;
    logic [POS_W:0]         trial;
    logic [POS_W:0]         trial_sub;
    logic                   q_bit;

    always_comb begin
        mag       = acc_reg[NUM_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
        trial     = {rem_reg, quo_reg[SAMPLE_BITS-1]};
        q_bit     = trial >= {1'b0, s_reg};
        trial_sub = trial - {1'b0, s_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep_div) begin
            neg_reg <= acc_reg[NUM_W-1];
            rem_reg <= mag[SAMPLE_BITS+POS_W-1:SAMPLE_BITS];
            quo_reg <= mag[SAMPLE_BITS-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], q_bit};
        end
    end

    // Output register.
    logic      m_valid_reg;
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.merged_sample <= neg_reg ? signed'(-quo_reg) : signed'(quo_reg);
            m_data_reg.block_end     <= bend_reg;
            m_data_reg.clip_end      <= cend_reg;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

/* rtl/overlap_crossfade_time_compressor.sv */
// Top level of the overlap crossfade time compressor.
//
//  channel   direction  signals                          payload
//  s_        in         s_valid, s_ready, s_data         in_item_t (sample, restart)
//  m_        out        m_valid, m_ready, m_data         out_item_t (merged_sample, flags)
//  cfg_      in         cfg_valid, cfg_ready, cfg_index  cfg_data, register write
//
// A request that stores, is dropped or is ignored visits only the take and decide states.
// A crossfading request then runs two multiply steps, the divider setup and the
// one-bit-per-cycle divider by S, plus any wait for the output register.
// The output register lets a new request be taken while a result waits.
// Reset is synchronous and active low; the store holds no reset value.
module overlap_crossfade_time_compressor import oct_pkg::*; #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    oct_cmd_t    cmd;
    oct_status_t status;

    assign cfg_ready = 1'b1;

    oct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    oct_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .m_ready   (m_ready)
    );

endmodule

/* rtl/oct_checker.sv */
// Port-level checker for the overlap crossfade time compressor, with its bind.
module oct_checker import oct_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // No result is presented right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One request is worked on at a time, so ready drops after every request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while the previous one is in progress");

    // The clip ends only on the last sample of a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clip_end |-> m_data.block_end)
        else $error("clip_end without block_end");

endmodule

bind overlap_crossfade_time_compressor oct_checker u_oct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
